/* src/mdbc_pkg.sv */
// Shared types and constants for the motor direction and brake controller.
// Used by mdbc_ctrl, mdbc_datapath and motor_direction_brake_controller_unit.
package mdbc_pkg;

  // Field widths of the item formats.
  localparam int DUTY_W  = 10;
  localparam int SPEED_W = 16;
  localparam int BTN_N   = 4;
  localparam int DRIVE_W = 5;

  // Configuration register widths, indexes and reset values.
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PPR    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GEAR   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW = 2'd2;
  localparam logic [7:0] PPR_RESET    = 8'd11;
  localparam logic [7:0] GEAR_RESET   = 8'd30;
  localparam logic [3:0] WINDOW_RESET = 4'd5;

  // Event kinds.
  localparam logic [1:0] MODE_POLL  = 2'd0;
  localparam logic [1:0] MODE_CMD   = 2'd1;
  localparam logic [1:0] MODE_PULSE = 2'd2;
  localparam logic [1:0] MODE_TICK  = 2'd3;

  // Command characters.
  localparam logic [7:0] CHAR_START   = 8'h54;  // 'T'
  localparam logic [7:0] CHAR_FORWARD = 8'h46;  // 'F'
  localparam logic [7:0] CHAR_REVERSE = 8'h42;  // 'B'
  localparam logic [7:0] CHAR_BRAKE   = 8'h53;  // 'S'
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;

  // Bit positions in the drive vector.
  localparam int DB_A      = 0;
  localparam int DB_B      = 1;
  localparam int DB_RED    = 2;
  localparam int DB_GREEN  = 3;
  localparam int DB_YELLOW = 4;

  // Speed arithmetic: speed = count * 60000 / (ppr * gear * window * 100).
  localparam logic [15:0] SPEED_SCALE  = 16'd60000;
  localparam logic [6:0]  WINDOW_SCALE = 7'd100;
  localparam int PG_W  = 16;          // ppr * gear
  localparam int WS_W  = 11;          // window * 100
  localparam int DEN_W = 27;          // full denominator
  localparam int REM_W = DEN_W + 1;   // divider partial remainder

  typedef enum logic [2:0] {
    RS_IDLE   = 3'd0,
    RS_READY  = 3'd1,
    RS_FWD    = 3'd2,
    RS_REV    = 3'd3,
    RS_BRAKED = 3'd4
  } run_state_t;

  typedef enum logic [2:0] {
    C_IDLE  = 3'd0,
    C_MUL_A = 3'd1,
    C_MUL_B = 3'd2,
    C_DIV   = 3'd3,
    C_EMIT  = 3'd4
  } ctl_state_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic              btn_start;
    logic              btn_forward;
    logic              btn_reverse;
    logic              btn_brake;
    logic [DUTY_W-1:0] pot_level;
    logic [7:0]        rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         run_state;
    logic               bridge_a;
    logic               bridge_b;
    logic               led_red;
    logic               led_green;
    logic               led_yellow;
    logic [DUTY_W-1:0]  duty_main;
    logic [DUTY_W-1:0]  duty_aux;
    logic [SPEED_W-1:0] speed_rpm;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic mul_a;
    logic mul_b;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic win_end;
    logic div_last;
  } dp_stat_t;

endpackage

/* src/mdbc_ctrl.sv */
// Sequencing controller: accepts items, runs the speed multiply and divide
// steps and hands the result to the output register. Depends on mdbc_pkg.
module mdbc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  mdbc_pkg::dp_stat_t stat,
  output mdbc_pkg::dp_cmd_t  cmd
);

  mdbc_pkg::ctl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mdbc_pkg::C_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.win_end ? mdbc_pkg::C_MUL_A : mdbc_pkg::C_EMIT;
        end
      end
      mdbc_pkg::C_MUL_A: state_nxt = mdbc_pkg::C_MUL_B;
      mdbc_pkg::C_MUL_B: state_nxt = mdbc_pkg::C_DIV;
      mdbc_pkg::C_DIV: begin
        if (stat.div_last) begin
          state_nxt = mdbc_pkg::C_EMIT;
        end
      end
      mdbc_pkg::C_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = mdbc_pkg::C_IDLE;
        end
      end
      default: state_nxt = mdbc_pkg::C_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == mdbc_pkg::C_IDLE) && in_valid;
    cmd.mul_a    = (state_r == mdbc_pkg::C_MUL_A);
    cmd.mul_b    = (state_r == mdbc_pkg::C_MUL_B);
    cmd.div_step = (state_r == mdbc_pkg::C_DIV);
    // The output register takes a new item once the previous one is gone.
    cmd.load_out = (state_r == mdbc_pkg::C_EMIT) && (!out_valid_r || !out_stall);
    in_stall     = (state_r != mdbc_pkg::C_IDLE);
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mdbc_pkg::C_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == mdbc_pkg::C_EMIT))
    else $error("result presented outside the emit step");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mdbc_pkg::C_DIV |=> state_r == mdbc_pkg::C_DIV || state_r == mdbc_pkg::C_EMIT)
    else $error("division left without emitting a result");

  a_short_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !stat.win_end |=> state_r == mdbc_pkg::C_EMIT)
    else $error("item without speed update did not go straight to emit");

endmodule

/* src/mdbc_datapath.sv */
// Datapath: button edge detect, direction interlock, pulse and tick counters,
// speed multiply and restoring divider, output register. Depends on mdbc_pkg.
module mdbc_datapath #(
  parameter int COUNT_WIDTH = 16,
  parameter int DUTY_MAX    = 1023
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mdbc_pkg::in_item_t                   in_item,
  input  logic                                 cfg_we,
  input  logic [mdbc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mdbc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  mdbc_pkg::dp_cmd_t                    cmd,
  output mdbc_pkg::dp_stat_t                   stat,
  output mdbc_pkg::out_item_t                  out_item
);

  localparam int NUM_W = COUNT_WIDTH + 16;
  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [mdbc_pkg::DUTY_W-1:0] DUTY_MAX_V = mdbc_pkg::DUTY_W'(DUTY_MAX);

  // Configuration registers.
  logic [7:0] ppr_r, gear_r;
  logic [3:0] window_r;

  // Interlock state.
  mdbc_pkg::run_state_t               run_r, run_nxt;
  logic [mdbc_pkg::BTN_N-1:0]         prev_r, prev_nxt;
  logic [7:0]                         latched_r, latched_nxt;
  logic [mdbc_pkg::DRIVE_W-1:0]       drive_r, drive_nxt;
  logic [mdbc_pkg::DUTY_W-1:0]        duty_main_r, duty_main_nxt;
  logic [mdbc_pkg::DUTY_W-1:0]        duty_aux_r, duty_aux_nxt;

  // Speed meter state.
  logic [COUNT_WIDTH-1:0]             pulse_r, pulse_nxt;
  logic [3:0]                         tick_r, tick_nxt;
  logic [COUNT_WIDTH-1:0]             pcap_r;
  logic [mdbc_pkg::SPEED_W-1:0]       speed_r;

  // Multiply and divide registers.
  logic [mdbc_pkg::PG_W-1:0]          pg_r;
  logic [mdbc_pkg::WS_W-1:0]          ws_r;
  logic [mdbc_pkg::DEN_W-1:0]         den_r;
  logic [NUM_W-1:0]                   num_r;
  logic [mdbc_pkg::REM_W-1:0]         rem_r;
  logic [mdbc_pkg::SPEED_W-1:0]       quo_r;
  logic [CNT_W-1:0]                   cnt_r;

  logic                               poll, go_start, go_fwd, go_rev, go_brake;
  logic [mdbc_pkg::BTN_N-1:0]         cur, press;
  logic [mdbc_pkg::DUTY_W-1:0]        pot;
  logic [3:0]                         tick_inc;
  logic [mdbc_pkg::REM_W-1:0]         rem_shift, rem_next;
  logic                               q_bit;
  logic                               win_end, div_last;

  // Event decode and button edges.
  always_comb begin
    poll  = cmd.accept && (in_item.mode == mdbc_pkg::MODE_POLL);
    cur   = {in_item.btn_brake, in_item.btn_reverse, in_item.btn_forward, in_item.btn_start};
    press = cur & ~prev_r;
    pot   = (int'(in_item.pot_level) > DUTY_MAX) ? DUTY_MAX_V : in_item.pot_level;
    go_start = press[0] || (latched_r == mdbc_pkg::CHAR_START);
    go_fwd   = press[1] || (latched_r == mdbc_pkg::CHAR_FORWARD);
    go_rev   = press[2] || (latched_r == mdbc_pkg::CHAR_REVERSE);
    go_brake = press[3] || (latched_r == mdbc_pkg::CHAR_BRAKE);
  end

  // Interlock next state.
  always_comb begin
    run_nxt = run_r;
    if (poll) begin
      case (run_r)
        mdbc_pkg::RS_IDLE: begin
          if (go_start) run_nxt = mdbc_pkg::RS_READY;
        end
        mdbc_pkg::RS_READY: begin
          if (go_fwd) begin
            run_nxt = mdbc_pkg::RS_FWD;
          end else if (go_rev) begin
            run_nxt = mdbc_pkg::RS_REV;
          end
        end
        mdbc_pkg::RS_FWD: begin
          if (go_brake) begin
            run_nxt = mdbc_pkg::RS_BRAKED;
          end else if (go_rev) begin
            run_nxt = mdbc_pkg::RS_REV;
          end
        end
        mdbc_pkg::RS_REV: begin
          if (go_brake) begin
            run_nxt = mdbc_pkg::RS_BRAKED;
          end else if (go_fwd) begin
            run_nxt = mdbc_pkg::RS_FWD;
          end
        end
        mdbc_pkg::RS_BRAKED: begin
          if (go_start) run_nxt = mdbc_pkg::RS_READY;
        end
        default: run_nxt = mdbc_pkg::RS_IDLE;
      endcase
    end
  end

  // Interlock outputs: bridge, lamps, duties and the latched command.
  always_comb begin
    drive_nxt     = drive_r;
    duty_main_nxt = duty_main_r;
    duty_aux_nxt  = duty_aux_r;
    latched_nxt   = latched_r;
    if (cmd.accept && (in_item.mode == mdbc_pkg::MODE_CMD) &&
        (in_item.rx_byte != mdbc_pkg::CHAR_CR) && (in_item.rx_byte != mdbc_pkg::CHAR_LF)) begin
      latched_nxt = in_item.rx_byte;
    end
    if (poll) begin
      case (run_r)
        mdbc_pkg::RS_IDLE: begin
          // The first start clears the latched command.
          if (go_start) latched_nxt = '0;
        end
        mdbc_pkg::RS_READY: begin
          if (go_fwd) begin
            drive_nxt[mdbc_pkg::DB_A]   = 1'b1;
            drive_nxt[mdbc_pkg::DB_RED] = 1'b1;
            drive_nxt[mdbc_pkg::DB_B]   = 1'b0;
            duty_main_nxt = pot;
            duty_aux_nxt  = pot;
          end else if (go_rev) begin
            drive_nxt[mdbc_pkg::DB_B]     = 1'b1;
            drive_nxt[mdbc_pkg::DB_GREEN] = 1'b1;
            drive_nxt[mdbc_pkg::DB_A]     = 1'b0;
            duty_main_nxt = pot;
            duty_aux_nxt  = pot;
          end
        end
        mdbc_pkg::RS_FWD, mdbc_pkg::RS_REV: begin
          duty_main_nxt = pot;
          duty_aux_nxt  = pot;
          if (go_brake) begin
            if (run_r == mdbc_pkg::RS_FWD) begin
              drive_nxt[mdbc_pkg::DB_RED] = 1'b0;
            end else begin
              drive_nxt[mdbc_pkg::DB_GREEN] = 1'b0;
            end
            drive_nxt[mdbc_pkg::DB_YELLOW] = 1'b1;
            drive_nxt[mdbc_pkg::DB_A]      = 1'b1;
            drive_nxt[mdbc_pkg::DB_B]      = 1'b1;
            duty_aux_nxt = DUTY_MAX_V;
          end else if ((run_r == mdbc_pkg::RS_FWD) && go_rev) begin
            drive_nxt[mdbc_pkg::DB_RED]   = 1'b0;
            drive_nxt[mdbc_pkg::DB_A]     = 1'b0;
            drive_nxt[mdbc_pkg::DB_GREEN] = 1'b1;
            drive_nxt[mdbc_pkg::DB_B]     = 1'b1;
          end else if ((run_r == mdbc_pkg::RS_REV) && go_fwd) begin
            drive_nxt[mdbc_pkg::DB_GREEN] = 1'b0;
            drive_nxt[mdbc_pkg::DB_B]     = 1'b0;
            drive_nxt[mdbc_pkg::DB_RED]   = 1'b1;
            drive_nxt[mdbc_pkg::DB_A]     = 1'b1;
          end
        end
        mdbc_pkg::RS_BRAKED: begin
          if (go_start) begin
            drive_nxt[mdbc_pkg::DB_YELLOW] = 1'b0;
            drive_nxt[mdbc_pkg::DB_A]      = 1'b0;
            drive_nxt[mdbc_pkg::DB_B]      = 1'b0;
            duty_main_nxt = '0;
            duty_aux_nxt  = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Buttons, pulse count and tick window.
  always_comb begin
    prev_nxt  = poll ? cur : prev_r;
    pulse_nxt = pulse_r;
    tick_inc  = tick_r + 4'd1;
    tick_nxt  = tick_r;
    win_end   = (in_item.mode == mdbc_pkg::MODE_TICK) && (tick_inc >= window_r);
    if (cmd.accept) begin
      case (in_item.mode)
        mdbc_pkg::MODE_PULSE: pulse_nxt = pulse_r + COUNT_WIDTH'(1);
        mdbc_pkg::MODE_TICK: begin
          if (win_end) begin
            tick_nxt  = '0;
            pulse_nxt = '0;
          end else begin
            tick_nxt = tick_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // One restoring divide step per cycle. A zero denominator yields all-one
  // quotient bits, which is the saturated speed.
  always_comb begin
    rem_shift = {rem_r[mdbc_pkg::REM_W-2:0], num_r[NUM_W-1]};
    q_bit     = (rem_shift >= {1'b0, den_r});
    rem_next  = q_bit ? (rem_shift - {1'b0, den_r}) : rem_shift;
    div_last  = (cnt_r == CNT_W'(NUM_W - 1));
  end

  always_comb begin
    stat.win_end  = win_end;
    stat.div_last = div_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r       <= mdbc_pkg::PPR_RESET;
      gear_r      <= mdbc_pkg::GEAR_RESET;
      window_r    <= mdbc_pkg::WINDOW_RESET;
      run_r       <= mdbc_pkg::RS_IDLE;
      prev_r      <= '1;
      latched_r   <= '0;
      drive_r     <= '0;
      duty_main_r <= '0;
      duty_aux_r  <= '0;
      pulse_r     <= '0;
      tick_r      <= '0;
      speed_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mdbc_pkg::CFG_PPR:    ppr_r    <= cfg_wdata;
          mdbc_pkg::CFG_GEAR:   gear_r   <= cfg_wdata;
          mdbc_pkg::CFG_WINDOW: window_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      run_r       <= run_nxt;
      prev_r      <= prev_nxt;
      latched_r   <= latched_nxt;
      drive_r     <= drive_nxt;
      duty_main_r <= duty_main_nxt;
      duty_aux_r  <= duty_aux_nxt;
      pulse_r     <= pulse_nxt;
      tick_r      <= tick_nxt;
      if (cmd.div_step && div_last) begin
        speed_r <= {quo_r[mdbc_pkg::SPEED_W-2:0], q_bit};
      end
    end
  end

  // Arithmetic and output registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.accept && win_end) begin
      pcap_r <= pulse_r;
    end
    if (cmd.mul_a) begin
      pg_r  <= mdbc_pkg::PG_W'(ppr_r) * mdbc_pkg::PG_W'(gear_r);
      ws_r  <= mdbc_pkg::WS_W'(window_r) * mdbc_pkg::WS_W'(mdbc_pkg::WINDOW_SCALE);
      num_r <= NUM_W'(pcap_r) * NUM_W'(mdbc_pkg::SPEED_SCALE);
    end
    if (cmd.mul_b) begin
      den_r <= mdbc_pkg::DEN_W'(pg_r) * mdbc_pkg::DEN_W'(ws_r);
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_next;
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      quo_r <= {quo_r[mdbc_pkg::SPEED_W-2:0], q_bit};
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.load_out) begin
      out_item.run_state  <= run_r;
      out_item.bridge_a   <= drive_r[mdbc_pkg::DB_A];
      out_item.bridge_b   <= drive_r[mdbc_pkg::DB_B];
      out_item.led_red    <= drive_r[mdbc_pkg::DB_RED];
      out_item.led_green  <= drive_r[mdbc_pkg::DB_GREEN];
      out_item.led_yellow <= drive_r[mdbc_pkg::DB_YELLOW];
      out_item.duty_main  <= duty_main_r;
      out_item.duty_aux   <= duty_aux_r;
      out_item.speed_rpm  <= speed_r;
    end
  end

  a_fwd_drive: assert property (@(posedge clk) disable iff (!rst_n)
    run_r == mdbc_pkg::RS_FWD |->
      drive_r[mdbc_pkg::DB_A] && !drive_r[mdbc_pkg::DB_B] && drive_r[mdbc_pkg::DB_RED])
    else $error("forward state with wrong bridge or lamp");

  a_rev_drive: assert property (@(posedge clk) disable iff (!rst_n)
    run_r == mdbc_pkg::RS_REV |->
      drive_r[mdbc_pkg::DB_B] && !drive_r[mdbc_pkg::DB_A] && drive_r[mdbc_pkg::DB_GREEN])
    else $error("reverse state with wrong bridge or lamp");

  a_brake_lamp: assert property (@(posedge clk) disable iff (!rst_n)
    drive_r[mdbc_pkg::DB_YELLOW] == (run_r == mdbc_pkg::RS_BRAKED))
    else $error("brake lamp disagrees with braked state");

endmodule

/* src/motor_direction_brake_controller_unit.sv */
// DC motor direction and brake interlock with speed meter.
// The package is mdbc_pkg; the top level joins mdbc_ctrl and mdbc_datapath.
//
// Each accepted item (button poll, command byte, encoder pulse or 100 ms tick)
// gives exactly one result item showing the bridge, lamps, duties, run state
// and last measured speed after that event. Polls, command bytes, pulses and
// ticks that do not close the measurement window go straight to the emit
// step. A tick that closes the window runs the multiply steps to build the
// numerator and denominator, then a restoring divider produces one quotient
// bit per cycle over all COUNT_WIDTH + 16 numerator bits. The block takes one
// item at a time; while the output register holds an item that is not yet
// taken, the next item is still accepted and its result waits for the register
// to empty. Configuration registers are written directly, with no read-back;
// the user must write them only while no item is in work; this is not enforced.
module motor_direction_brake_controller_unit #(
  parameter int COUNT_WIDTH = 16,
  parameter int DUTY_MAX    = 1023
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  mdbc_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output mdbc_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [mdbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mdbc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  mdbc_pkg::dp_cmd_t  cmd;
  mdbc_pkg::dp_stat_t stat;

  mdbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mdbc_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .DUTY_MAX    (DUTY_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item)
  );

endmodule

/* sim/tb_motor_direction_brake_controller_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for motor_direction_brake_controller_unit.
// Depends on mdbc_pkg and the unit under test; a built-in predictor of the
// interlock and speed meter checks every result item.
module tb_motor_direction_brake_controller_unit;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int PRINT_LIMIT    = 100;
  localparam logic [mdbc_pkg::DUTY_W-1:0] DUTY_FULL = 10'd1023;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mdbc_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mdbc_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [mdbc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mdbc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  motor_direction_brake_controller_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state, mirroring the block after each accepted item.
  mdbc_pkg::run_state_t motor_st = mdbc_pkg::RS_IDLE;
  logic [mdbc_pkg::BTN_N-1:0] prev_btn = '1;
  logic [7:0] latched_char = 8'd0;
  logic [mdbc_pkg::DRIVE_W-1:0] drive = '0;
  logic [mdbc_pkg::DUTY_W-1:0] duty_m = '0;
  logic [mdbc_pkg::DUTY_W-1:0] duty_x = '0;
  logic [15:0] pulse_cnt = '0;
  logic [3:0] win_ticks = '0;
  logic [mdbc_pkg::SPEED_W-1:0] speed = '0;
  logic [7:0] cfg_ppr = mdbc_pkg::PPR_RESET;
  logic [7:0] cfg_gear = mdbc_pkg::GEAR_RESET;
  logic [3:0] cfg_win = mdbc_pkg::WINDOW_RESET;

  mdbc_pkg::out_item_t expected_q[$];
  mdbc_pkg::out_item_t oldest_expected;
  int mismatch_cnt = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_len = 0;
  int hold_left = 0;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;

  function automatic mdbc_pkg::out_item_t step_motor(mdbc_pkg::in_item_t it);
    logic [mdbc_pkg::BTN_N-1:0] cur;
    logic [mdbc_pkg::BTN_N-1:0] press;
    logic go_start, go_fwd, go_rev, go_brake;
    logic [63:0] num, den;
    mdbc_pkg::out_item_t r;
    case (it.mode)
      mdbc_pkg::MODE_POLL: begin
        cur = {it.btn_brake, it.btn_reverse, it.btn_forward, it.btn_start};
        press = cur & ~prev_btn;
        go_start = press[0] || latched_char == mdbc_pkg::CHAR_START;
        go_fwd   = press[1] || latched_char == mdbc_pkg::CHAR_FORWARD;
        go_rev   = press[2] || latched_char == mdbc_pkg::CHAR_REVERSE;
        go_brake = press[3] || latched_char == mdbc_pkg::CHAR_BRAKE;
        case (motor_st)
          mdbc_pkg::RS_IDLE: begin
            if (go_start) begin
              motor_st = mdbc_pkg::RS_READY;
              latched_char = 8'd0;
            end
          end
          mdbc_pkg::RS_READY: begin
            if (go_fwd) begin
              motor_st = mdbc_pkg::RS_FWD;
              drive[mdbc_pkg::DB_A] = 1'b1;
              drive[mdbc_pkg::DB_RED] = 1'b1;
              drive[mdbc_pkg::DB_B] = 1'b0;
              duty_m = it.pot_level;
              duty_x = it.pot_level;
            end else if (go_rev) begin
              motor_st = mdbc_pkg::RS_REV;
              drive[mdbc_pkg::DB_B] = 1'b1;
              drive[mdbc_pkg::DB_GREEN] = 1'b1;
              drive[mdbc_pkg::DB_A] = 1'b0;
              duty_m = it.pot_level;
              duty_x = it.pot_level;
            end
          end
          mdbc_pkg::RS_FWD, mdbc_pkg::RS_REV: begin
            duty_m = it.pot_level;
            duty_x = it.pot_level;
            if (go_brake) begin
              if (motor_st == mdbc_pkg::RS_FWD) drive[mdbc_pkg::DB_RED] = 1'b0;
              else drive[mdbc_pkg::DB_GREEN] = 1'b0;
              drive[mdbc_pkg::DB_YELLOW] = 1'b1;
              drive[mdbc_pkg::DB_A] = 1'b1;
              drive[mdbc_pkg::DB_B] = 1'b1;
              duty_x = DUTY_FULL;
              motor_st = mdbc_pkg::RS_BRAKED;
            end else if (motor_st == mdbc_pkg::RS_FWD && go_rev) begin
              drive[mdbc_pkg::DB_RED] = 1'b0;
              drive[mdbc_pkg::DB_A] = 1'b0;
              drive[mdbc_pkg::DB_GREEN] = 1'b1;
              drive[mdbc_pkg::DB_B] = 1'b1;
              motor_st = mdbc_pkg::RS_REV;
            end else if (motor_st == mdbc_pkg::RS_REV && go_fwd) begin
              drive[mdbc_pkg::DB_GREEN] = 1'b0;
              drive[mdbc_pkg::DB_B] = 1'b0;
              drive[mdbc_pkg::DB_RED] = 1'b1;
              drive[mdbc_pkg::DB_A] = 1'b1;
              motor_st = mdbc_pkg::RS_FWD;
            end
          end
          mdbc_pkg::RS_BRAKED: begin
            if (go_start) begin
              drive[mdbc_pkg::DB_YELLOW] = 1'b0;
              drive[mdbc_pkg::DB_A] = 1'b0;
              drive[mdbc_pkg::DB_B] = 1'b0;
              duty_m = '0;
              duty_x = '0;
              motor_st = mdbc_pkg::RS_READY;
            end
          end
          default: motor_st = mdbc_pkg::RS_IDLE;
        endcase
        prev_btn = cur;
      end
      mdbc_pkg::MODE_CMD: begin
        if (it.rx_byte != mdbc_pkg::CHAR_CR && it.rx_byte != mdbc_pkg::CHAR_LF)
          latched_char = it.rx_byte;
      end
      mdbc_pkg::MODE_PULSE: pulse_cnt = pulse_cnt + 16'd1;
      default: begin
        win_ticks = win_ticks + 4'd1;
        if (win_ticks >= cfg_win) begin
          den = 64'(cfg_ppr) * 64'(cfg_gear) * 64'(cfg_win) * 64'd100;
          num = 64'(pulse_cnt) * 64'(mdbc_pkg::SPEED_SCALE);
          speed = (den == 64'd0) ? 16'hFFFF : 16'(num / den);
          win_ticks = '0;
          pulse_cnt = '0;
        end
      end
    endcase
    r.run_state  = motor_st;
    r.bridge_a   = drive[mdbc_pkg::DB_A];
    r.bridge_b   = drive[mdbc_pkg::DB_B];
    r.led_red    = drive[mdbc_pkg::DB_RED];
    r.led_green  = drive[mdbc_pkg::DB_GREEN];
    r.led_yellow = drive[mdbc_pkg::DB_YELLOW];
    r.duty_main  = duty_m;
    r.duty_aux   = duty_x;
    r.speed_rpm  = speed;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatch_cnt < PRINT_LIMIT)
      $display("%0t ns: result %0d %s: got %0d, expected %0d",
               $time, results_seen, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_result(mdbc_pkg::out_item_t got, mdbc_pkg::out_item_t want);
    if (got.run_state !== want.run_state)
      report_mismatch("run_state", got.run_state, want.run_state);
    if (got.bridge_a !== want.bridge_a) report_mismatch("bridge_a", got.bridge_a, want.bridge_a);
    if (got.bridge_b !== want.bridge_b) report_mismatch("bridge_b", got.bridge_b, want.bridge_b);
    if (got.led_red !== want.led_red) report_mismatch("led_red", got.led_red, want.led_red);
    if (got.led_green !== want.led_green)
      report_mismatch("led_green", got.led_green, want.led_green);
    if (got.led_yellow !== want.led_yellow)
      report_mismatch("led_yellow", got.led_yellow, want.led_yellow);
    if (got.duty_main !== want.duty_main)
      report_mismatch("duty_main", got.duty_main, want.duty_main);
    if (got.duty_aux !== want.duty_aux) report_mismatch("duty_aux", got.duty_aux, want.duty_aux);
    if (got.speed_rpm !== want.speed_rpm)
      report_mismatch("speed_rpm", got.speed_rpm, want.speed_rpm);
  endtask

  // Results are checked before the same edge's input item is predicted, so a
  // result is always matched against items accepted at earlier edges.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("item with nothing expected", 64'(out_item), 64'd0);
        end else begin
          oldest_expected = expected_q.pop_front();
          check_result(out_item, oldest_expected);
        end
        results_seen++;
      end
      if (in_valid && !in_stall) expected_q.push_back(step_motor(in_item));
    end
  end

  // Receiver: random stalls, or a long hold requested by a test.
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_motor_direction_brake_controller_unit: FAIL");
        $finish;
      end
    end
  end

  function automatic mdbc_pkg::in_item_t random_fields();
    logic [31:0] r;
    r = $urandom;
    return r[$bits(mdbc_pkg::in_item_t)-1:0];
  endfunction

  function automatic mdbc_pkg::in_item_t mk_poll(logic s, logic f, logic rv, logic b,
                                                 logic [mdbc_pkg::DUTY_W-1:0] pot);
    mdbc_pkg::in_item_t it;
    it = random_fields();
    it.mode = mdbc_pkg::MODE_POLL;
    it.btn_start = s;
    it.btn_forward = f;
    it.btn_reverse = rv;
    it.btn_brake = b;
    it.pot_level = pot;
    return it;
  endfunction

  function automatic mdbc_pkg::in_item_t mk_event(logic [1:0] mode);
    mdbc_pkg::in_item_t it;
    it = random_fields();
    it.mode = mode;
    return it;
  endfunction

  function automatic mdbc_pkg::in_item_t mk_cmd(logic [7:0] ch);
    mdbc_pkg::in_item_t it;
    it = mk_event(mdbc_pkg::MODE_CMD);
    it.rx_byte = ch;
    return it;
  endfunction

  // Mostly polls and pulses; half of the command bytes are meaningful characters.
  function automatic mdbc_pkg::in_item_t rand_item();
    mdbc_pkg::in_item_t it;
    int pick;
    it = random_fields();
    pick = $urandom_range(99);
    if (pick < 40) it.mode = mdbc_pkg::MODE_POLL;
    else if (pick < 55) it.mode = mdbc_pkg::MODE_CMD;
    else if (pick < 88) it.mode = mdbc_pkg::MODE_PULSE;
    else it.mode = mdbc_pkg::MODE_TICK;
    case ($urandom_range(9))
      0: it.pot_level = '0;
      1: it.pot_level = '1;
      default: ;
    endcase
    if (it.mode == mdbc_pkg::MODE_CMD && $urandom_range(1) == 1) begin
      case ($urandom_range(5))
        0: it.rx_byte = mdbc_pkg::CHAR_START;
        1: it.rx_byte = mdbc_pkg::CHAR_FORWARD;
        2: it.rx_byte = mdbc_pkg::CHAR_REVERSE;
        3: it.rx_byte = mdbc_pkg::CHAR_BRAKE;
        4: it.rx_byte = mdbc_pkg::CHAR_CR;
        default: it.rx_byte = mdbc_pkg::CHAR_LF;
      endcase
    end
    return it;
  endfunction

  // Valid stays high between back-to-back items; it only drops during a gap.
  task automatic send_item(mdbc_pkg::in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_results_done;
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic program_speed(logic [7:0] ppr, logic [7:0] gear, logic [3:0] win);
    wait_results_done;
    cfg_we <= 1'b1;
    cfg_index <= mdbc_pkg::CFG_PPR;
    cfg_wdata <= ppr;
    @(posedge clk);
    cfg_index <= mdbc_pkg::CFG_GEAR;
    cfg_wdata <= gear;
    @(posedge clk);
    cfg_index <= mdbc_pkg::CFG_WINDOW;
    cfg_wdata <= mdbc_pkg::CFG_DATA_W'(win);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_ppr = ppr;
    cfg_gear = gear;
    cfg_win = win;
  endtask

  // Button edges through every state, starting from the all-pressed reset value.
  task automatic test_interlock_buttons;
    send_item(mk_poll(1'b1, 1'b1, 1'b1, 1'b1, 10'd1023));
    send_item(mk_poll(1'b0, 1'b0, 1'b0, 1'b0, 10'd0));
    send_item(mk_poll(1'b1, 1'b0, 1'b0, 1'b0, 10'd5));
    send_item(mk_poll(1'b1, 1'b1, 1'b0, 1'b0, 10'd1023));
    send_item(mk_poll(1'b0, 1'b1, 1'b0, 1'b0, 10'd512));
    send_item(mk_poll(1'b0, 1'b0, 1'b1, 1'b0, 10'd0));
    send_item(mk_poll(1'b0, 1'b1, 1'b0, 1'b0, 10'd700));
    send_item(mk_poll(1'b0, 1'b0, 1'b0, 1'b1, 10'd341));
    send_item(mk_poll(1'b0, 1'b1, 1'b0, 1'b0, 10'd99));
    send_item(mk_poll(1'b1, 1'b0, 1'b0, 1'b0, 10'd1023));
    send_item(mk_poll(1'b0, 1'b0, 1'b1, 1'b0, 10'd682));
    send_item(mk_poll(1'b0, 1'b0, 1'b0, 1'b1, 10'd1));
  endtask

  // Latched characters act on later polls, but the first start clears the latch; line endings leave it alone.
  task automatic test_command_latch;
    send_item(mk_cmd(mdbc_pkg::CHAR_START));
    send_item(mk_cmd(mdbc_pkg::CHAR_CR));
    send_item(mk_cmd(mdbc_pkg::CHAR_LF));
    send_item(mk_poll(1'b0, 1'b0, 1'b0, 1'b0, 10'd300));
    send_item(mk_cmd(mdbc_pkg::CHAR_REVERSE));
    send_item(mk_poll(1'b0, 1'b0, 1'b0, 1'b0, 10'd400));
    send_item(mk_poll(1'b0, 1'b0, 1'b0, 1'b0, 10'd401));
    send_item(mk_cmd(mdbc_pkg::CHAR_FORWARD));
    send_item(mk_poll(1'b0, 1'b0, 1'b0, 1'b0, 10'd1));
    send_item(mk_cmd(mdbc_pkg::CHAR_BRAKE));
    send_item(mk_poll(1'b0, 1'b0, 1'b0, 1'b0, 10'd1022));
    send_item(mk_poll(1'b0, 1'b0, 1'b0, 1'b0, 10'd0));
    send_item(mk_cmd(mdbc_pkg::CHAR_START));
    send_item(mk_poll(1'b0, 1'b0, 1'b0, 1'b0, 10'd77));
  endtask

  // With the smallest nonzero divisor the quotient no longer fits in 16 bits.
  task automatic test_speed_truncation;
    program_speed(8'd1, 8'd1, 4'd1);
    send_item(mk_event(mdbc_pkg::MODE_TICK));
    repeat (110) send_item(mk_event(mdbc_pkg::MODE_PULSE));
    send_item(mk_event(mdbc_pkg::MODE_TICK));
  endtask

  // The receiver holds off long enough for the block to back up its input.
  task automatic test_output_hold;
    wait_results_done;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_len <= 150;
    hold_go <= ~hold_go;
    repeat (12) send_item(rand_item());
    wait_results_done;
  endtask

  task automatic run_random_phase(int n, int src_pct, int sink_pct,
                                  logic [7:0] ppr, logic [7:0] gear, logic [3:0] win);
    program_speed(ppr, gear, win);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    repeat (n) send_item(rand_item());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_interlock_buttons;
    test_command_latch;
    test_speed_truncation;
    test_output_hold;
    run_random_phase(210, 23, 81, 8'd1, 8'd1, 4'd1);
    run_random_phase(210, 81, 23, 8'd255, 8'd255, 4'd15);
    run_random_phase(210, 0, 0, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                     4'($urandom_range(1, 15)));
    wait_results_done;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb_motor_direction_brake_controller_unit: PASS");
    end else begin
      $display("tb_motor_direction_brake_controller_unit: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
src/mdbc_pkg.sv
src/mdbc_ctrl.sv
src/mdbc_datapath.sv
src/motor_direction_brake_controller_unit.sv
sim/tb_motor_direction_brake_controller_unit.sv
